/* rtl/lsbs_pkg.sv */
// lsbs_pkg: shared types and constants of the lidar scan breakpoint segmenter
// holds controller states, command and status bundles, register indexes and
// fixed-point constants; no dependencies
`default_nettype none

package lsbs_pkg;

	// configuration port
	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-1:0] CFG_DIST_THRESHOLD_SQ = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_START       = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_STEP        = 2'd2;

	localparam logic [31:0] RST_DIST_THRESHOLD_SQ = 32'd40000;
	localparam logic [15:0] RST_ANGLE_START       = 16'd0;
	localparam logic [15:0] RST_ANGLE_STEP        = 16'd182;

	// stream widths
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 48;
	localparam int unsigned COORD_W    = 17;
	localparam int unsigned CLUSTER_W  = 10;

	// quarter-wave sine polynomial, q15
	localparam logic [16:0] POLY_C0 = 17'd51472;
	localparam logic [16:0] POLY_C1 = 17'd21024;
	localparam logic [16:0] POLY_C2 = 17'd2320;
	localparam logic [16:0] Q15_ONE = 17'd32768;
	localparam logic [32:0] ROUND_HALF = 33'd16384;

	typedef enum logic [1:0] {
		QUAD_I,
		QUAD_II,
		QUAD_III,
		QUAD_IV
	} quad_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ANGLE,
		S_CHOOSE,
		S_LT_GO,
		S_LT_WAIT,
		S_LMUL,
		S_LACC,
		S_LCMP,
		S_ET_GO,
		S_ET_WAIT,
		S_EPROJ,
		S_COMMIT,
		S_LAST,
		S_EMPTY,
		S_CLEAR
	} state_t;

	typedef struct packed {
		logic in_load;     // capture the accepted beam
		logic angle_calc;  // beam angle from start, index and step
		logic trig_start;  // launch sine/cosine unit
		logic trig_link;   // 1: angle difference for link test, 0: point angle
		logic link_wrap;   // link against first point instead of current beam
		logic link_mul;
		logic link_acc;
		logic link_cmp;
		logic out_load;    // project previous point into output register
		logic out_empty;   // closing record of an empty scan
		logic commit;      // current beam becomes previous point
		logic beam_inc;
		logic scan_clear;
	} cmd_t;

	typedef struct packed {
		logic beam_valid;
		logic beam_last;
		logic has_prev;
		logic trig_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/lsbs_trig.sv */
// lsbs_trig: sine and cosine of a 16-bit angle, q15, one shared multiplier
// eight steps per request; uses lsbs_pkg
`default_nettype none

module lsbs_trig #(
	parameter int TRIG_TABLE_DEPTH = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [15:0]        angle,
	output logic                    done,
	output logic signed [16:0]      cos_q15,
	output logic signed [16:0]      sin_q15
);

	// depth is a power of two: quantising keeps the top bits of the angle
	localparam int TB = $clog2(TRIG_TABLE_DEPTH);
	localparam logic [15:0] QMASK = 16'(((1 << TB) - 1) << (16 - TB));

	logic                busy_q;
	logic [2:0]          step_q;
	logic                done_q;
	lsbs_pkg::quad_t     quad_q;
	logic [14:0]         z_q;
	logic [16:0]         z2_q, t_q, ra_q, rb_q;
	logic [15:0]         p;
	logic [16:0]         x, opa, opb, sh;
	logic [33:0]         prod;

	assign p = angle & QMASK;
	// step bit 2 selects the complementary argument
	assign x = step_q[2] ? (lsbs_pkg::Q15_ONE - {2'b00, z_q}) : {2'b00, z_q};

	always_comb begin
		case (step_q[1:0])
			2'd0: begin
				opa = x;
				opb = x;
			end
			2'd1: begin
				opa = lsbs_pkg::POLY_C2;
				opb = z2_q;
			end
			2'd2: begin
				opa = t_q;
				opb = z2_q;
			end
			default: begin
				opa = t_q;
				opb = x;
			end
		endcase
	end

	assign prod = opa * opb;
	assign sh   = prod[31:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quad_q <= lsbs_pkg::quad_t'(p[15:14]);
			z_q    <= {p[13:0], 1'b0};
		end else if (busy_q) begin
			case (step_q[1:0])
				2'd0: z2_q <= sh;
				2'd1: t_q  <= lsbs_pkg::POLY_C1 - sh;
				2'd2: t_q  <= lsbs_pkg::POLY_C0 - sh;
				default: begin
					if (step_q[2]) begin
						rb_q <= sh;
					end else begin
						ra_q <= sh;
					end
				end
			endcase
		end
	end

	always_comb begin
		case (quad_q)
			lsbs_pkg::QUAD_I: begin
				sin_q15 = $signed(ra_q);
				cos_q15 = $signed(rb_q);
			end
			lsbs_pkg::QUAD_II: begin
				sin_q15 = $signed(rb_q);
				cos_q15 = -$signed(ra_q);
			end
			lsbs_pkg::QUAD_III: begin
				sin_q15 = -$signed(ra_q);
				cos_q15 = -$signed(rb_q);
			end
			default: begin
				sin_q15 = -$signed(rb_q);
				cos_q15 = $signed(ra_q);
			end
		endcase
	end

	assign done = done_q;

endmodule

`default_nettype wire

/* rtl/lsbs_dp.sv */
// lsbs_dp: datapath of the segmenter: configuration, point state, link test,
// projection and output register; uses lsbs_pkg and lsbs_trig
`default_nettype none

module lsbs_dp #(
	parameter int MAX_BEAMS        = 1024,
	parameter int TRIG_TABLE_DEPTH = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire lsbs_pkg::cmd_t                    cmd,
	output lsbs_pkg::sts_t                         sts,
	input  wire logic                              cfg_we,
	input  wire logic [lsbs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [lsbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic [lsbs_pkg::IN_DATA_W-1:0]    s_tdata,
	input  wire logic                              s_tuser,
	input  wire logic                              s_tlast,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [lsbs_pkg::OUT_DATA_W-1:0]        m_tdata,
	output logic                                   m_tuser,
	output logic                                   m_tlast
);

	localparam int BW = $clog2(MAX_BEAMS);
	localparam logic [BW-1:0] BEAM_LAST = BW'(MAX_BEAMS - 1);

	logic [31:0]  thr_q;
	logic [15:0]  ang_start_q, ang_step_q;
	logic [15:0]  in_range_q;
	logic         in_valid_q, in_last_q;
	logic [15:0]  cur_angle_q;
	logic [15:0]  prev_range_q, prev_angle_q, first_range_q, first_angle_q;
	logic         has_q, link_in_q, link_q;
	logic [BW-1:0] beam_q;
	logic [lsbs_pkg::CLUSTER_W-1:0] cluster_q;

	logic [31:0]         sq1_s1, sq2_s1, rr_s1;
	logic [32:0]         sum_s2;
	logic signed [49:0]  prod_s2;

	logic                                out_valid_q;
	logic signed [lsbs_pkg::COORD_W-1:0] out_x_q, out_y_q;
	logic                                out_lp_q, out_ln_q, out_wrec_q, out_wl_q, out_last_q;
	logic [lsbs_pkg::CLUSTER_W-1:0]      out_cl_q;

	logic [BW+15:0]      ang_prod;
	logic [15:0]         r2, a2, trig_angle;
	logic                trig_done;
	logic signed [16:0]  trig_cos, trig_sin;
	logic signed [51:0]  dist_sq, lim;
	logic [16:0]         vx, vy;
	logic [15:0]         cmag, smag;
	logic [31:0]         px, py;
	logic                clus_inc;

	// link partner: the current beam, or the first point for the wrap link
	assign r2 = cmd.link_wrap ? first_range_q : in_range_q;
	assign a2 = cmd.link_wrap ? first_angle_q : cur_angle_q;
	assign trig_angle = cmd.trig_link ? (a2 - prev_angle_q) : prev_angle_q;
	assign ang_prod = beam_q * ang_step_q;

	lsbs_trig #(
		.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)
	) u_trig (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.trig_start),
		.angle   (trig_angle),
		.done    (trig_done),
		.cos_q15 (trig_cos),
		.sin_q15 (trig_sin)
	);

	// squared distance scaled by 2^15 against threshold scaled alike
	assign dist_sq = $signed({4'b0000, sum_s2, 15'd0}) - $signed({prod_s2[49], prod_s2, 1'b0});
	assign lim     = $signed({5'b00000, thr_q, 15'd0});

	// projection, rounding half away from zero
	assign cmag = trig_cos[16] ? 16'(-trig_cos) : trig_cos[15:0];
	assign smag = trig_sin[16] ? 16'(-trig_sin) : trig_sin[15:0];
	assign px   = prev_range_q * cmag;
	assign py   = prev_range_q * smag;
	assign vx   = 17'(({1'b0, px} + lsbs_pkg::ROUND_HALF) >> 15);
	assign vy   = 17'(({1'b0, py} + lsbs_pkg::ROUND_HALF) >> 15);
	assign clus_inc = link_q && !link_in_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= lsbs_pkg::RST_DIST_THRESHOLD_SQ;
			ang_start_q <= lsbs_pkg::RST_ANGLE_START;
			ang_step_q  <= lsbs_pkg::RST_ANGLE_STEP;
		end else if (cfg_we) begin
			case (cfg_addr)
				lsbs_pkg::CFG_DIST_THRESHOLD_SQ: thr_q       <= cfg_wdata;
				lsbs_pkg::CFG_ANGLE_START:       ang_start_q <= cfg_wdata[15:0];
				lsbs_pkg::CFG_ANGLE_STEP:        ang_step_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_range_q  <= '0;
			prev_angle_q  <= '0;
			first_range_q <= '0;
			first_angle_q <= '0;
			has_q         <= 1'b0;
			link_in_q     <= 1'b0;
			beam_q        <= '0;
			cluster_q     <= '0;
		end else if (cmd.scan_clear) begin
			prev_range_q  <= '0;
			prev_angle_q  <= '0;
			first_range_q <= '0;
			first_angle_q <= '0;
			has_q         <= 1'b0;
			link_in_q     <= 1'b0;
			beam_q        <= '0;
			cluster_q     <= '0;
		end else begin
			if (cmd.out_load && clus_inc) begin
				cluster_q <= cluster_q + 1'b1;
			end
			if (cmd.beam_inc) begin
				beam_q <= (beam_q == BEAM_LAST) ? '0 : beam_q + 1'b1;
			end
			if (cmd.commit && in_valid_q) begin
				if (has_q) begin
					link_in_q <= link_q;
				end else begin
					first_range_q <= in_range_q;
					first_angle_q <= cur_angle_q;
					link_in_q     <= 1'b0;
				end
				prev_range_q <= in_range_q;
				prev_angle_q <= cur_angle_q;
				has_q        <= 1'b1;
			end
		end
	end

	// beam capture and link arithmetic
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			in_range_q <= s_tdata;
			in_valid_q <= s_tuser;
			in_last_q  <= s_tlast;
		end
		if (cmd.angle_calc) begin
			cur_angle_q <= ang_start_q + ang_prod[15:0];
		end
		if (cmd.link_mul) begin
			sq1_s1 <= prev_range_q * prev_range_q;
			sq2_s1 <= r2 * r2;
			rr_s1  <= prev_range_q * r2;
		end
		if (cmd.link_acc) begin
			sum_s2  <= {1'b0, sq1_s1} + {1'b0, sq2_s1};
			prod_s2 <= $signed({1'b0, rr_s1}) * trig_cos;
		end
		if (cmd.link_cmp) begin
			link_q <= (dist_sq < lim);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load || cmd.out_empty) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_x_q    <= trig_cos[16] ? -$signed(vx) : $signed(vx);
			out_y_q    <= trig_sin[16] ? -$signed(vy) : $signed(vy);
			out_lp_q   <= link_in_q;
			out_ln_q   <= link_q;
			out_cl_q   <= cluster_q + {{(lsbs_pkg::CLUSTER_W-1){1'b0}}, clus_inc};
			out_wrec_q <= cmd.link_wrap;
			out_wl_q   <= cmd.link_wrap && link_q;
			out_last_q <= cmd.link_wrap;
		end else if (cmd.out_empty) begin
			out_x_q    <= '0;
			out_y_q    <= '0;
			out_lp_q   <= 1'b0;
			out_ln_q   <= 1'b0;
			out_cl_q   <= cluster_q;
			out_wrec_q <= 1'b1;
			out_wl_q   <= 1'b0;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_wl_q, out_cl_q, out_ln_q, out_lp_q, out_y_q, out_x_q};
	assign m_tuser  = out_wrec_q;
	assign m_tlast  = out_last_q;

	assign sts.beam_valid = in_valid_q;
	assign sts.beam_last  = in_last_q;
	assign sts.has_prev   = has_q;
	assign sts.trig_done  = trig_done;
	assign sts.out_free   = !out_valid_q || m_tready;

endmodule

`default_nettype wire

/* rtl/lsbs_ctrl.sv */
// lsbs_ctrl: sequencing state machine of the segmenter
// drives lsbs_dp through the command bundle; uses lsbs_pkg
`default_nettype none

module lsbs_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire lsbs_pkg::sts_t   sts,
	output lsbs_pkg::cmd_t        cmd
);

	lsbs_pkg::state_t state_q, state_d;
	logic             wrap_q, wrap_d;
	logic             accept;

	assign s_tready = (state_q == lsbs_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		wrap_d  = wrap_q;
		case (state_q)
			lsbs_pkg::S_IDLE: begin
				if (accept) state_d = lsbs_pkg::S_ANGLE;
			end
			lsbs_pkg::S_ANGLE:   state_d = lsbs_pkg::S_CHOOSE;
			lsbs_pkg::S_CHOOSE: begin
				state_d = (sts.beam_valid && sts.has_prev) ? lsbs_pkg::S_LT_GO
				                                           : lsbs_pkg::S_COMMIT;
			end
			lsbs_pkg::S_LT_GO:   state_d = lsbs_pkg::S_LT_WAIT;
			lsbs_pkg::S_LT_WAIT: begin
				if (sts.trig_done) state_d = lsbs_pkg::S_LMUL;
			end
			lsbs_pkg::S_LMUL:    state_d = lsbs_pkg::S_LACC;
			lsbs_pkg::S_LACC:    state_d = lsbs_pkg::S_LCMP;
			lsbs_pkg::S_LCMP:    state_d = lsbs_pkg::S_ET_GO;
			lsbs_pkg::S_ET_GO:   state_d = lsbs_pkg::S_ET_WAIT;
			lsbs_pkg::S_ET_WAIT: begin
				if (sts.trig_done) state_d = lsbs_pkg::S_EPROJ;
			end
			lsbs_pkg::S_EPROJ: begin
				if (sts.out_free) state_d = wrap_q ? lsbs_pkg::S_CLEAR : lsbs_pkg::S_COMMIT;
			end
			lsbs_pkg::S_COMMIT:  state_d = lsbs_pkg::S_LAST;
			lsbs_pkg::S_LAST: begin
				if (!sts.beam_last) begin
					state_d = lsbs_pkg::S_IDLE;
				end else if (sts.has_prev) begin
					state_d = lsbs_pkg::S_LT_GO;
					wrap_d  = 1'b1;
				end else begin
					state_d = lsbs_pkg::S_EMPTY;
				end
			end
			lsbs_pkg::S_EMPTY: begin
				if (sts.out_free) state_d = lsbs_pkg::S_IDLE;
			end
			lsbs_pkg::S_CLEAR: begin
				state_d = lsbs_pkg::S_IDLE;
				wrap_d  = 1'b0;
			end
			default: state_d = lsbs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.link_wrap  = wrap_q;
		cmd.in_load    = accept;
		case (state_q)
			lsbs_pkg::S_ANGLE: cmd.angle_calc = 1'b1;
			lsbs_pkg::S_LT_GO: begin
				cmd.trig_start = 1'b1;
				cmd.trig_link  = 1'b1;
			end
			lsbs_pkg::S_LMUL:  cmd.link_mul = 1'b1;
			lsbs_pkg::S_LACC:  cmd.link_acc = 1'b1;
			lsbs_pkg::S_LCMP:  cmd.link_cmp = 1'b1;
			lsbs_pkg::S_ET_GO: cmd.trig_start = 1'b1;
			lsbs_pkg::S_EPROJ: cmd.out_load = sts.out_free;
			lsbs_pkg::S_COMMIT: cmd.commit = 1'b1;
			lsbs_pkg::S_LAST:  cmd.beam_inc = !sts.beam_last;
			lsbs_pkg::S_EMPTY: begin
				cmd.out_empty  = sts.out_free;
				cmd.scan_clear = sts.out_free;
			end
			lsbs_pkg::S_CLEAR: cmd.scan_clear = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsbs_pkg::S_IDLE;
			wrap_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			wrap_q  <= wrap_d;
		end
	end

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load || cmd.out_empty) |-> sts.out_free)
		else $error("output register overwritten");

	a_one_beam_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second beam taken while busy");

	a_trig_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		sts.trig_done |-> (state_q == lsbs_pkg::S_LT_WAIT || state_q == lsbs_pkg::S_ET_WAIT))
		else $error("trig result arrived while not waiting");

endmodule

`default_nettype wire

/* rtl/lidar_scan_breakpoint_segmenter_top.sv */
// lidar_scan_breakpoint_segmenter_top: top level of the breakpoint segmenter
// joins lsbs_ctrl and lsbs_dp; uses lsbs_pkg
//
// usage
//  - input stream: one beam per transfer; s_tdata = range in mm, s_tuser = 1 when
//    the beam has a return, s_tlast marks the final beam of the scan
//  - output stream: each valid point once the next valid beam arrives, with x, y,
//    link flags and cluster number; the final transfer of a scan is the closing
//    record (m_tuser = 1, m_tlast = 1) carrying the wrap link to the first point
//  - an empty scan still yields one closing record with zero payload
//  - config port: cfg_we writes register cfg_addr (0 threshold, 1 start angle,
//    2 angle step) at once; write only while the block is idle
//  - throughput: one beam at a time; a beam without a link test skips the
//    sine/cosine unit, a beam that links and emits calls it twice, a final beam
//    that also closes the scan up to four times; the sine/cosine unit (8
//    multiplier steps per call) dominates
//  - a finished result waits in the output register while the next beam is
//    taken; a stalled receiver holds the block only once it has a second result
//  - reset clears registers to defaults and the scan state; no clearing pass
//  - MAX_BEAMS sets the beam index width; TRIG_TABLE_DEPTH (power of two) sets
//    the angle quantisation
`default_nettype none

module lidar_scan_breakpoint_segmenter_top #(
	parameter int MAX_BEAMS        = 1024,
	parameter int TRIG_TABLE_DEPTH = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              cfg_we,
	input  wire logic [lsbs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [lsbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// beam input
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [lsbs_pkg::IN_DATA_W-1:0]    s_tdata,  // [15:0] range_mm
	input  wire logic                              s_tuser,  // [0] range_valid
	input  wire logic                              s_tlast,  // last_beam
	// point output
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [16:0] x_mm, [33:17] y_mm, [34] link_prev, [35] link_next,
	// [45:36] cluster_number, [46] wrap_link, [47] zero
	output logic [lsbs_pkg::OUT_DATA_W-1:0]        m_tdata,
	output logic                                   m_tuser,  // [0] wrap_record
	output logic                                   m_tlast   // last_result
);

	lsbs_pkg::cmd_t cmd;
	lsbs_pkg::sts_t sts;

	// controller: handshake on the input side and step sequencing
	lsbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: registers, trig unit, link test, output register
	lsbs_dp #(
		.MAX_BEAMS        (MAX_BEAMS),
		.TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

/* tb/sv/lidar_scan_breakpoint_segmenter_top_test.sv */
// lidar_scan_breakpoint_segmenter_top_test: self-checking bench for the breakpoint segmenter
// drives beam scans and register writes, predicts every output transfer in a scoreboard
// class; depends on lsbs_pkg and lidar_scan_breakpoint_segmenter_top
`default_nettype none

module lidar_scan_breakpoint_segmenter_top_test;

	localparam int BEAM_WRAP = 1024;

	// one expected output transfer
	typedef struct packed {
		logic        last;
		logic        user;
		logic [47:0] data;
	} point_rec_t;

	// segment predictor and store of expected points
	class segment_scoreboard;
		logic [31:0] thr_sq;
		logic [15:0] a_start;
		logic [15:0] a_step;
		logic [15:0] prev_r, prev_a, first_r, first_a;
		bit          has_prev, prev_lin;
		int          beam_idx;
		logic [9:0]  cluster_cnt;
		point_rec_t  pending_points[$];
		int          mismatches;
		int          points_seen;

		function new();
			thr_sq = lsbs_pkg::RST_DIST_THRESHOLD_SQ;
			a_start = lsbs_pkg::RST_ANGLE_START;
			a_step = lsbs_pkg::RST_ANGLE_STEP;
			mismatches = 0;
			points_seen = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			prev_r = 0;
			prev_a = 0;
			first_r = 0;
			first_a = 0;
			has_prev = 0;
			prev_lin = 0;
			beam_idx = 0;
			cluster_cnt = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				lsbs_pkg::CFG_DIST_THRESHOLD_SQ: thr_sq = val;
				lsbs_pkg::CFG_ANGLE_START: a_start = val[15:0];
				lsbs_pkg::CFG_ANGLE_STEP: a_step = val[15:0];
				default: ;
			endcase
		endfunction

		// q15 sine over a quarter turn, every product truncated
		function longint quarter_sine(longint z);
			longint z2, t;
			z2 = (z * z) >>> 15;
			t = (2320 * z2) >>> 15;
			t = 21024 - t;
			t = (t * z2) >>> 15;
			t = 51472 - t;
			return (t * z) >>> 15;
		endfunction

		function void sin_cos(input logic [15:0] ang, output longint c, output longint s);
			logic [15:0] p;
			longint z, a, b;
			// angle quantised to the 1024-entry table grid
			p = {ang[15:6], 6'd0};
			z = longint'(p[13:0]) << 1;
			a = quarter_sine(z);
			b = quarter_sine(32768 - z);
			case (lsbs_pkg::quad_t'(p[15:14]))
				lsbs_pkg::QUAD_I:   begin s = a;  c = b;  end
				lsbs_pkg::QUAD_II:  begin s = b;  c = -a; end
				lsbs_pkg::QUAD_III: begin s = -a; c = -b; end
				default:            begin s = -b; c = a;  end
			endcase
		endfunction

		// squared law-of-cosines distance against the threshold, scaled by 2^15
		function bit is_close(logic [15:0] r1, logic [15:0] a1, logic [15:0] r2, logic [15:0] a2);
			longint c, s, d, x1, x2;
			logic [15:0] da;
			da = a2 - a1;
			sin_cos(da, c, s);
			x1 = r1;
			x2 = r2;
			d = (x1 * x1 + x2 * x2) * 32768 - 2 * x1 * x2 * c;
			return d < longint'(thr_sq) * 32768;
		endfunction

		function logic [16:0] project(logic [15:0] r, longint t);
			longint mag, v;
			mag = (t < 0) ? -t : t;
			v = (longint'(r) * mag + 16384) >>> 15;
			if (t < 0)
				v = -v;
			return v[16:0];
		endfunction

		function void push_point(logic [15:0] r, logic [15:0] a, bit lp, bit ln,
				bit wrec, bit wl, bit lst);
			longint c, s;
			point_rec_t p;
			sin_cos(a, c, s);
			// a point opening a cluster bumps the count before it goes out
			if (ln && !lp)
				cluster_cnt = cluster_cnt + 10'd1;
			p.data = {1'b0, wl, cluster_cnt, ln, lp, project(r, s), project(r, c)};
			p.user = wrec;
			p.last = lst;
			pending_points = {pending_points, p};
		endfunction

		// note one accepted beam and queue the points it releases
		function void note_beam(logic [15:0] r, bit v, bit lst);
			logic [15:0] ang;
			bit lk;
			point_rec_t p;
			ang = a_start + 16'(beam_idx % BEAM_WRAP) * a_step;
			if (v) begin
				if (has_prev) begin
					lk = is_close(prev_r, prev_a, r, ang);
					push_point(prev_r, prev_a, prev_lin, lk, 0, 0, 0);
					prev_lin = lk;
				end else begin
					first_r = r;
					first_a = ang;
					prev_lin = 0;
				end
				prev_r = r;
				prev_a = ang;
				has_prev = 1;
			end
			if (lst) begin
				if (has_prev) begin
					lk = is_close(prev_r, prev_a, first_r, first_a);
					push_point(prev_r, prev_a, prev_lin, lk, 1, lk, 1);
				end else begin
					// empty scan: closing record with zero payload
					p.data = 48'd0;
					p.data[45:36] = cluster_cnt;
					p.user = 1;
					p.last = 1;
					pending_points = {pending_points, p};
				end
				clear_scan();
			end else begin
				beam_idx = (beam_idx + 1) % BEAM_WRAP;
			end
		endfunction

		function void cmp_field(string fname, longint e, longint a);
			if (e != a) begin
				mismatches++;
				$display("%0t mismatch %s: expected %0d actual %0d", $time, fname, e, a);
			end
		endfunction

		function void check_point(logic [47:0] d, logic u, logic l);
			point_rec_t e;
			points_seen++;
			if (pending_points.size() == 0) begin
				mismatches++;
				$display("%0t unexpected point: expected none actual %h/%b/%b", $time, d, u, l);
				return;
			end
			e = pending_points.pop_front();
			cmp_field("x_mm", $signed(e.data[16:0]), $signed(d[16:0]));
			cmp_field("y_mm", $signed(e.data[33:17]), $signed(d[33:17]));
			cmp_field("link_prev", e.data[34], d[34]);
			cmp_field("link_next", e.data[35], d[35]);
			cmp_field("cluster_number", e.data[45:36], d[45:36]);
			cmp_field("wrap_link", e.data[46], d[46]);
			cmp_field("pad bit", e.data[47], d[47]);
			cmp_field("wrap_record", e.user, u);
			cmp_field("last_result", e.last, l);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [31:0] cfg_wdata;
	logic        s_tvalid, s_tready, s_tuser, s_tlast;
	logic [15:0] s_tdata;
	logic        m_tvalid, m_tready, m_tuser, m_tlast;
	logic [47:0] m_tdata;

	segment_scoreboard sb;
	int  rx_hold;     // receiver stall cycles still to run
	bit  calm;        // phase with no idling on either side
	int  beams_sent;
	int  scans_sent;

	lidar_scan_breakpoint_segmenter_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#30000000;
		$display("[lidar_scan_breakpoint_segmenter_top] ERROR");
		$finish;
	end

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (calm || k < 60)
			return 0;
		if (k < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver side: random tready, long holds counted here
	initial begin
		int k;
		m_tready <= 0;
		rx_hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				m_tready <= 0;
				rx_hold--;
			end else if (calm) begin
				m_tready <= 1;
			end else begin
				k = $urandom_range(0, 99);
				if (k < 8) begin
					m_tready <= 0;
					rx_hold = $urandom_range(0, 2);
				end else if (k < 10) begin
					m_tready <= 0;
					rx_hold = $urandom_range(10, 40);
				end else begin
					m_tready <= 1;
				end
			end
		end
	end

	// outputs are stable at the falling edge; the transfer completes on the next rise
	always @(negedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_point(m_tdata, m_tuser, m_tlast);

	// one beam transfer, entered and left at a rising edge
	task automatic send_beam(logic [15:0] r, bit v, bit lst);
		int g;
		s_tvalid <= 1;
		s_tdata <= r;
		s_tuser <= v;
		s_tlast <= lst;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		sb.note_beam(r, v, lst);
		beams_sent++;
		if (lst)
			scans_sent++;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	// write enable drops before the next write may start
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// drain: all points in, then cover the longest beam latency
	task automatic settle();
		s_tvalid <= 0;
		@(posedge clk);
		while (sb.pending_points.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// one scan of well-formed beams: ranges walk slowly so links are common
	task automatic clustered_scan(int n);
		int base, i;
		bit v;
		base = $urandom_range(0, 65535);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				base = $urandom_range(0, 65535);
			else if ($urandom_range(0, 5) == 0)
				base = base + $urandom_range(0, 4000) - 2000;
			else
				base = base + $urandom_range(0, 60) - 30;
			if (base < 0)
				base = 0;
			if (base > 65535)
				base = 65535;
			v = ($urandom_range(0, 9) != 0);
			send_beam(16'(base), v, i == n - 1);
		end
	endtask

	// noise scan: any range, any validity
	task automatic noise_scan(int n);
		int i;
		for (i = 0; i < n; i++)
			send_beam(16'($urandom), $urandom_range(0, 1), i == n - 1);
	endtask

	task automatic random_config();
		int k;
		k = $urandom_range(0, 5);
		case (k)
			0: write_reg(lsbs_pkg::CFG_DIST_THRESHOLD_SQ, 32'd0);
			1: write_reg(lsbs_pkg::CFG_DIST_THRESHOLD_SQ, 32'hFFFF_FFFF);
			2: write_reg(lsbs_pkg::CFG_DIST_THRESHOLD_SQ, $urandom);
			default: write_reg(lsbs_pkg::CFG_DIST_THRESHOLD_SQ, $urandom_range(0, 200000));
		endcase
		write_reg(lsbs_pkg::CFG_ANGLE_START, $urandom_range(0, 1)
			? 32'($urandom_range(0, 65535))
			: ($urandom_range(0, 1) ? 32'd0 : 32'hFFFF));
		k = $urandom_range(0, 9);
		if (k == 0)
			write_reg(lsbs_pkg::CFG_ANGLE_STEP, 32'd0);
		else if (k == 1)
			write_reg(lsbs_pkg::CFG_ANGLE_STEP, 32'hFFFF);
		else if (k == 2)
			write_reg(lsbs_pkg::CFG_ANGLE_STEP, $urandom_range(0, 65535));
		else
			write_reg(lsbs_pkg::CFG_ANGLE_STEP, $urandom_range(1, 400));
	endtask

	initial begin
		int i, s;
		sb = new();
		beams_sent = 0;
		scans_sent = 0;
		calm = 0;
		arst_n <= 0;
		cfg_we <= 0;
		cfg_addr <= lsbs_pkg::CFG_DIST_THRESHOLD_SQ;
		cfg_wdata <= 0;
		s_tvalid <= 0;
		s_tdata <= 0;
		s_tuser <= 0;
		s_tlast <= 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty scan, then a lone point that wraps onto itself
		send_beam(16'd0, 0, 1);
		send_beam(16'hFFFF, 1, 1);
		// close points, range extremes, a dropped beam inside the scan
		send_beam(16'd1000, 1, 0);
		send_beam(16'd1000, 1, 0);
		send_beam(16'd1010, 1, 0);
		send_beam(16'd0, 1, 0);
		send_beam(16'hFFFF, 1, 0);
		send_beam(16'h1234, 0, 0);
		send_beam(16'd5000, 1, 0);
		send_beam(16'd5000, 1, 1);
		// all beams without a return
		send_beam(16'hAAAA, 0, 0);
		send_beam(16'h5555, 0, 1);
		settle();
		// nothing links, extreme angles
		write_reg(lsbs_pkg::CFG_DIST_THRESHOLD_SQ, 32'd0);
		write_reg(lsbs_pkg::CFG_ANGLE_START, 32'hFFFF);
		write_reg(lsbs_pkg::CFG_ANGLE_STEP, 32'hFFFF);
		send_beam(16'd300, 1, 0);
		send_beam(16'd300, 1, 0);
		send_beam(16'd40000, 1, 1);
		settle();
		// everything links
		write_reg(lsbs_pkg::CFG_DIST_THRESHOLD_SQ, 32'hFFFF_FFFF);
		write_reg(lsbs_pkg::CFG_ANGLE_STEP, 32'd0);
		send_beam(16'hFFFF, 1, 0);
		send_beam(16'd0, 1, 0);
		send_beam(16'd77, 0, 0);
		send_beam(16'd65000, 1, 1);
		settle();

		// long scan: beam index wraps past MAX_BEAMS
		write_reg(lsbs_pkg::CFG_DIST_THRESHOLD_SQ, 32'd40000);
		write_reg(lsbs_pkg::CFG_ANGLE_START, 32'd100);
		write_reg(lsbs_pkg::CFG_ANGLE_STEP, 32'd64);
		calm = 1;
		for (i = 0; i < 1030; i++)
			send_beam(16'(2000 + i), (i < 3) || (i > 1019), i == 1029);
		calm = 0;
		settle();

		// random scans under changing settings
		s = 0;
		while (beams_sent < 1250) begin
			if (s % 4 == 0) begin
				settle();
				calm = ($urandom_range(0, 5) == 0);
				random_config();
			end
			if (s == 2) begin
				// long receiver hold while beams keep coming
				rx_hold = 400;
				clustered_scan(30);
			end else if ($urandom_range(0, 9) < 8) begin
				clustered_scan($urandom_range(1, 30));
			end else begin
				noise_scan($urandom_range(1, 12));
			end
			s++;
		end
		settle();

		$display("covered %0d beams in %0d scans, %0d points checked",
			beams_sent, scans_sent, sb.points_seen);
		$display("thresholds, start angles and steps at extremes and random, long receiver hold");
		if (sb.mismatches == 0) begin
			$display("[lidar_scan_breakpoint_segmenter_top] OK");
		end else begin
			$display("[lidar_scan_breakpoint_segmenter_top] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
